// ===== hw/rtl/afbd_pkg.sv =====
// Shared types, widths, register map and arithmetic helpers of the box decoder.
package afbd_pkg;

    localparam int LOGIT_W = 16;
    localparam int DIST_W  = 16;
    localparam int GRID_W  = 10;
    localparam int COORD_W = 23;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 7;
    localparam int STRIDE_W = 8;
    localparam int OFFSET_W = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int SIG_STEPS = 24;

    localparam logic [1:0] REG_STRIDE    = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [STRIDE_W-1:0] STRIDE_RST    = 8'd8;
    localparam logic [OFFSET_W-1:0] OFFSET_RST    = 4'd0;
    localparam logic [SCORE_W-1:0]  THRESHOLD_RST = 16'd1311;

    localparam logic signed [COORD_W:0] COORD_HI = 24'sd4194303;
    localparam logic signed [COORD_W:0] COORD_LO = -24'sd4194304;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [OFFSET_W-1:0] offset_q4;
        logic [SCORE_W-1:0]  score_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] class_logit;
        logic                      last_class;
        logic [GRID_W-1:0]         grid_x;
        logic [GRID_W-1:0]         grid_y;
        logic signed [DIST_W-1:0]  dist_left;
        logic signed [DIST_W-1:0]  dist_top;
        logic signed [DIST_W-1:0]  dist_right;
        logic signed [DIST_W-1:0]  dist_bottom;
    } t_in_item;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] best_logit;
        logic [CLASS_W-1:0]        cls_idx;
        logic [GRID_W-1:0]         grid_x;
        logic [GRID_W-1:0]         grid_y;
        logic signed [DIST_W-1:0]  dist_left;
        logic signed [DIST_W-1:0]  dist_top;
        logic signed [DIST_W-1:0]  dist_right;
        logic signed [DIST_W-1:0]  dist_bottom;
    } t_cell_item;

    function automatic logic [SCORE_W-1:0] sig_point(input logic [4:0] idx);
        logic [SCORE_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            5'd16:   v = 16'd65514;
            5'd17:   v = 16'd65523;
            5'd18:   v = 16'd65528;
            5'd19:   v = 16'd65531;
            5'd20:   v = 16'd65533;
            5'd21:   v = 16'd65534;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
        logic [COORD_W-1:0] r;
        if (v > COORD_HI) begin
            r = COORD_HI[COORD_W-1:0];
        end else if (v < COORD_LO) begin
            r = COORD_LO[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/afbd_if.sv =====
// Valid/ready channel interfaces for logit requests and box results.
interface afbd_in_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [afbd_pkg::LOGIT_W-1:0]         class_logit;
    logic                                        last_class;
    logic [afbd_pkg::GRID_W-1:0]                 grid_x;
    logic [afbd_pkg::GRID_W-1:0]                 grid_y;
    logic signed [afbd_pkg::DIST_W-1:0]          dist_left;
    logic signed [afbd_pkg::DIST_W-1:0]          dist_top;
    logic signed [afbd_pkg::DIST_W-1:0]          dist_right;
    logic signed [afbd_pkg::DIST_W-1:0]          dist_bottom;

    modport source (
        output valid, class_logit, last_class, grid_x, grid_y,
               dist_left, dist_top, dist_right, dist_bottom,
        input  ready
    );
    modport sink (
        input  valid, class_logit, last_class, grid_x, grid_y,
               dist_left, dist_top, dist_right, dist_bottom,
        output ready
    );
endinterface

interface afbd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [afbd_pkg::COORD_W-1:0]  box_x1;
    logic signed [afbd_pkg::COORD_W-1:0]  box_y1;
    logic signed [afbd_pkg::COORD_W-1:0]  box_x2;
    logic signed [afbd_pkg::COORD_W-1:0]  box_y2;
    logic [afbd_pkg::SCORE_W-1:0]         score;
    logic [afbd_pkg::CLASS_W-1:0]         cls_idx;

    modport source (
        output valid, box_x1, box_y1, box_x2, box_y2, score, cls_idx,
        input  ready
    );
    modport sink (
        input  valid, box_x1, box_y1, box_x2, box_y2, score, cls_idx,
        output ready
    );
endinterface

// ===== hw/rtl/anchor_free_box_decode_core.sv =====
// Top level of the anchor-free box decoder with score threshold.
// A cell result passes the input register, the cell register and the result register.
// Throughput: one logit request per cycle while the output is not stalled.
// Each stage moves when the next is empty or drains, so bubbles are absorbed.
// Synchronous active-low reset clears pipeline valids and the cell state and
// loads stride 8, offset 0 and threshold 1311.
module anchor_free_box_decode_core #(
    parameter int MAX_CLASSES = 128,
    parameter int GRID_MAX    = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    afbd_in_if.sink                       i_in,
    afbd_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [afbd_pkg::DATA_W-1:0]   pwdata,
    output logic [afbd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    afbd_pkg::t_cfg       w_cfg;
    afbd_pkg::t_cell_item w_item;
    logic                 w_item_valid;
    logic                 w_dec_free;

    afbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    afbd_cell #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_cell (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_dec_free (w_dec_free),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    afbd_decode #(
        .GRID_MAX (GRID_MAX)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_valid),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_free  (w_dec_free),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/afbd_cfg.sv =====
// APB register file holding stride, anchor offset and score threshold.
module afbd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [afbd_pkg::DATA_W-1:0]   pwdata,
    output logic [afbd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output afbd_pkg::t_cfg                o_cfg
);

    afbd_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stride          <= afbd_pkg::STRIDE_RST;
            r_cfg.offset_q4       <= afbd_pkg::OFFSET_RST;
            r_cfg.score_threshold <= afbd_pkg::THRESHOLD_RST;
        end else if (w_wr) begin
            case (w_sel)
                afbd_pkg::REG_STRIDE:    r_cfg.stride <= pwdata[afbd_pkg::STRIDE_W-1:0];
                afbd_pkg::REG_OFFSET:    r_cfg.offset_q4 <= pwdata[afbd_pkg::OFFSET_W-1:0];
                afbd_pkg::REG_THRESHOLD: begin
                    r_cfg.score_threshold <= pwdata[afbd_pkg::SCORE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            afbd_pkg::REG_STRIDE:    prdata = 32'(r_cfg.stride);
            afbd_pkg::REG_OFFSET:    prdata = 32'(r_cfg.offset_q4);
            afbd_pkg::REG_THRESHOLD: prdata = 32'(r_cfg.score_threshold);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/afbd_cell.sv =====
// Input register and per-cell running maximum over class logits.
module afbd_cell #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    afbd_in_if.sink              i_in,
    input  logic                 i_dec_free,
    output logic                 o_valid,
    output afbd_pkg::t_cell_item o_item
);

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CLASSES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CLASSES - 1);

    afbd_pkg::t_in_item   r_s1;
    logic                 r_s1_valid;
    afbd_pkg::t_cell_item r_s2;
    logic                 r_s2_valid;

    logic signed [afbd_pkg::LOGIT_W-1:0] r_best;
    logic [IDX_W-1:0]                    r_best_cls;
    logic [CNT_W-1:0]                    r_cnt;

    logic signed [afbd_pkg::LOGIT_W-1:0] n_best;
    logic [IDX_W-1:0]                    n_best_cls;
    logic [CNT_W-1:0]                    n_cnt;

    logic             w_s2_free;
    logic             w_s1_free;
    logic             w_s1_fire;
    logic             w_take;
    logic [IDX_W-1:0] w_idx;

    assign w_s2_free = !r_s2_valid || i_dec_free;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign w_s1_fire = r_s1_valid && w_s2_free;
    assign i_in.ready = w_s1_free;

    assign w_idx  = (r_cnt >= CNT_MAX) ? IDX_LAST : IDX_W'(r_cnt);
    assign w_take = (r_cnt == '0) || (r_s1.class_logit > r_best);

    always_comb begin
        n_best     = w_take ? r_s1.class_logit : r_best;
        n_best_cls = w_take ? w_idx : r_best_cls;
        n_cnt      = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_best     <= '0;
            r_best_cls <= '0;
            r_cnt      <= '0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= w_s1_fire && r_s1.last_class;
            end
            if (w_s1_fire) begin
                if (r_s1.last_class) begin
                    r_best     <= '0;
                    r_best_cls <= '0;
                    r_cnt      <= '0;
                end else begin
                    r_best     <= n_best;
                    r_best_cls <= n_best_cls;
                    r_cnt      <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in.valid) begin
            r_s1.class_logit <= i_in.class_logit;
            r_s1.last_class  <= i_in.last_class;
            r_s1.grid_x      <= i_in.grid_x;
            r_s1.grid_y      <= i_in.grid_y;
            r_s1.dist_left   <= i_in.dist_left;
            r_s1.dist_top    <= i_in.dist_top;
            r_s1.dist_right  <= i_in.dist_right;
            r_s1.dist_bottom <= i_in.dist_bottom;
        end
        if (w_s1_fire && r_s1.last_class) begin
            r_s2.best_logit  <= n_best;
            r_s2.cls_idx     <= afbd_pkg::CLASS_W'(n_best_cls);
            r_s2.grid_x      <= r_s1.grid_x;
            r_s2.grid_y      <= r_s1.grid_y;
            r_s2.dist_left   <= r_s1.dist_left;
            r_s2.dist_top    <= r_s1.dist_top;
            r_s2.dist_right  <= r_s1.dist_right;
            r_s2.dist_bottom <= r_s1.dist_bottom;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("class counter beyond saturation");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && r_s1.last_class |=> r_cnt == '0 && r_s2_valid)
        else $error("last request did not close the cell");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !i_dec_free |=> r_s2_valid && $stable(r_s2))
        else $error("stalled cell result changed");

    a_no_fire_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s2_free |=> r_s1_valid && $stable(r_cnt))
        else $error("cell state advanced while stalled");
`endif

endmodule

// ===== hw/rtl/afbd_decode.sv =====
// Sigmoid lookup, threshold test, anchor and box decode into the result register.
module afbd_decode #(
    parameter int GRID_MAX = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  afbd_pkg::t_cell_item i_item,
    input  afbd_pkg::t_cfg       i_cfg,
    output logic                 o_free,
    afbd_out_if.source           o_out
);

    localparam logic [12:0] GRID_LAST = 13'(GRID_MAX - 1);

    logic                                 r_valid;
    logic signed [afbd_pkg::COORD_W-1:0]  r_x1;
    logic signed [afbd_pkg::COORD_W-1:0]  r_y1;
    logic signed [afbd_pkg::COORD_W-1:0]  r_x2;
    logic signed [afbd_pkg::COORD_W-1:0]  r_y2;
    logic [afbd_pkg::SCORE_W-1:0]         r_score;
    logic [afbd_pkg::CLASS_W-1:0]         r_class;

    logic [15:0] w_mag;
    logic [8:0]  w_k;
    logic [6:0]  w_f;
    logic        w_sat;
    logic [15:0] w_t0;
    logic [15:0] w_t1;
    logic [12:0] w_diff;
    logic [19:0] w_prod;
    logic [12:0] w_interp;
    logic [15:0] w_pos;
    logic [15:0] w_score;
    logic        w_pass;

    logic [9:0]  w_gx;
    logic [9:0]  w_gy;
    logic [21:0] w_ax;
    logic [21:0] w_ay;
    logic signed [afbd_pkg::COORD_W:0] w_axs;
    logic signed [afbd_pkg::COORD_W:0] w_ays;

    always_comb begin
        w_mag    = i_item.best_logit[15] ? (~i_item.best_logit + 16'd1)
                                         : i_item.best_logit;
        w_k      = w_mag[15:7];
        w_f      = w_mag[6:0];
        w_sat    = w_k >= 9'(afbd_pkg::SIG_STEPS);
        w_t0     = afbd_pkg::sig_point(w_k[4:0]);
        w_t1     = afbd_pkg::sig_point(w_k[4:0] + 5'd1);
        w_diff   = 13'(w_t1 - w_t0);
        w_prod   = 20'(w_diff) * 20'(w_f);
        w_interp = 13'((w_prod + 20'd64) >> 7);
        w_pos    = w_sat ? 16'hFFFF : w_t0 + 16'(w_interp);
        w_score  = i_item.best_logit[15] ? 16'(17'h10000 - 17'(w_pos)) : w_pos;
        w_pass   = w_score >= i_cfg.score_threshold;
    end

    always_comb begin
        w_gx  = (13'(i_item.grid_x) > GRID_LAST) ? GRID_LAST[9:0] : i_item.grid_x;
        w_gy  = (13'(i_item.grid_y) > GRID_LAST) ? GRID_LAST[9:0] : i_item.grid_y;
        w_ax  = 22'({w_gx, i_cfg.offset_q4}) * 22'(i_cfg.stride);
        w_ay  = 22'({w_gy, i_cfg.offset_q4}) * 22'(i_cfg.stride);
        w_axs = $signed({2'b00, w_ax});
        w_ays = $signed({2'b00, w_ay});
    end

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid && w_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_x1    <= afbd_pkg::sat_coord(w_axs - 24'(i_item.dist_left));
            r_y1    <= afbd_pkg::sat_coord(w_ays - 24'(i_item.dist_top));
            r_x2    <= afbd_pkg::sat_coord(w_axs + 24'(i_item.dist_right));
            r_y2    <= afbd_pkg::sat_coord(w_ays + 24'(i_item.dist_bottom));
            r_score <= w_score;
            r_class <= i_item.cls_idx;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.box_x1   = r_x1;
    assign o_out.box_y1   = r_y1;
    assign o_out.box_x2   = r_x2;
    assign o_out.box_y2   = r_y2;
    assign o_out.score    = r_score;
    assign o_out.cls_idx  = r_class;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the box decoder: cell streams, register settings and a scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CLASSES = 128;

    typedef struct packed {
        logic signed [afbd_pkg::COORD_W-1:0] x1;
        logic signed [afbd_pkg::COORD_W-1:0] y1;
        logic signed [afbd_pkg::COORD_W-1:0] x2;
        logic signed [afbd_pkg::COORD_W-1:0] y2;
        logic [afbd_pkg::SCORE_W-1:0]        score;
        logic [afbd_pkg::CLASS_W-1:0]        cls_idx;
    } t_box;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [afbd_pkg::ADDR_W-1:0]   paddr;
    logic [afbd_pkg::DATA_W-1:0]   pwdata;
    logic [afbd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    afbd_in_if  in_ch ();
    afbd_out_if out_ch ();

    anchor_free_box_decode_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    const int unsigned sig_knots [25] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
        64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
        65514, 65523, 65528, 65531, 65533, 65534, 65535, 65535,
        65535
    };

    int unsigned cfg_stride;
    int unsigned cfg_offset;
    int unsigned cfg_threshold;
    int          best_logit_q;
    int unsigned best_idx;
    int unsigned seen_count;

    t_box pending_boxes [$];
    int   boxes_predicted;
    int   mismatch_count;
    int   src_idle_pct;
    int   sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic int unsigned sigmoid_score(input int logit);
        int unsigned m;
        int unsigned k;
        int unsigned f;
        int unsigned s;
        m = (logit < 0) ? -logit : logit;
        k = m >> 7;
        f = m & 32'h7F;
        if (k >= 24) begin
            s = 65535;
        end else begin
            s = sig_knots[k] + (((sig_knots[k+1] - sig_knots[k]) * f + 64) >> 7);
        end
        return (logit < 0) ? 65536 - s : s;
    endfunction

    function automatic logic signed [afbd_pkg::COORD_W-1:0] clamp_coord(input longint v);
        if (v > longint'(afbd_pkg::COORD_HI)) begin
            return afbd_pkg::COORD_HI[afbd_pkg::COORD_W-1:0];
        end else if (v < longint'(afbd_pkg::COORD_LO)) begin
            return afbd_pkg::COORD_LO[afbd_pkg::COORD_W-1:0];
        end
        return v[afbd_pkg::COORD_W-1:0];
    endfunction

    task automatic decode_request(input afbd_pkg::t_in_item it);
        int          lg;
        int unsigned idx;
        int unsigned sc;
        longint      ax;
        longint      ay;
        t_box        b;
        lg  = $signed(it.class_logit);
        idx = (seen_count > MAX_CLASSES - 1) ? MAX_CLASSES - 1 : seen_count;
        if (seen_count == 0 || lg > best_logit_q) begin
            best_logit_q = lg;
            best_idx     = idx;
        end
        if (seen_count < MAX_CLASSES) begin
            seen_count++;
        end
        if (!it.last_class) begin
            return;
        end
        sc = sigmoid_score(best_logit_q);
        ax = (longint'(it.grid_x) * 16 + cfg_offset) * cfg_stride;
        ay = (longint'(it.grid_y) * 16 + cfg_offset) * cfg_stride;
        if (sc >= cfg_threshold) begin
            b.x1      = clamp_coord(ax - longint'($signed(it.dist_left)));
            b.y1      = clamp_coord(ay - longint'($signed(it.dist_top)));
            b.x2      = clamp_coord(ax + longint'($signed(it.dist_right)));
            b.y2      = clamp_coord(ay + longint'($signed(it.dist_bottom)));
            b.score   = sc[afbd_pkg::SCORE_W-1:0];
            b.cls_idx = best_idx[afbd_pkg::CLASS_W-1:0];
            pending_boxes.insert(pending_boxes.size(), b);
            boxes_predicted++;
        end
        best_logit_q = 0;
        best_idx     = 0;
        seen_count   = 0;
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_box               b;
        afbd_pkg::t_in_item it;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_boxes.size() == 0) begin
                    $display("%0t: unexpected box, expected none actual x1 %0d score %0d",
                             $time, out_ch.box_x1, out_ch.score);
                    mismatch_count++;
                end else begin
                    b = pending_boxes.pop_front();
                    check_field("box_x1", b.x1, out_ch.box_x1);
                    check_field("box_y1", b.y1, out_ch.box_y1);
                    check_field("box_x2", b.x2, out_ch.box_x2);
                    check_field("box_y2", b.y2, out_ch.box_y2);
                    check_field("score", b.score, out_ch.score);
                    check_field("cls_idx", b.cls_idx, out_ch.cls_idx);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                it.class_logit = in_ch.class_logit;
                it.last_class  = in_ch.last_class;
                it.grid_x      = in_ch.grid_x;
                it.grid_y      = in_ch.grid_y;
                it.dist_left   = in_ch.dist_left;
                it.dist_top    = in_ch.dist_top;
                it.dist_right  = in_ch.dist_right;
                it.dist_bottom = in_ch.dist_bottom;
                decode_request(it);
            end
        end
    end

    task automatic send_request(input afbd_pkg::t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.class_logit = it.class_logit;
        in_ch.last_class  = it.last_class;
        in_ch.grid_x      = it.grid_x;
        in_ch.grid_y      = it.grid_y;
        in_ch.dist_left   = it.dist_left;
        in_ch.dist_top    = it.dist_top;
        in_ch.dist_right  = it.dist_right;
        in_ch.dist_bottom = it.dist_bottom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_logit(input int logit, input bit last, input int gx, input int gy,
                              input int dl, input int dt, input int dr, input int db);
        afbd_pkg::t_in_item it;
        it.class_logit = logit[afbd_pkg::LOGIT_W-1:0];
        it.last_class  = last;
        it.grid_x      = gx[afbd_pkg::GRID_W-1:0];
        it.grid_y      = gy[afbd_pkg::GRID_W-1:0];
        it.dist_left   = dl[afbd_pkg::DIST_W-1:0];
        it.dist_top    = dt[afbd_pkg::DIST_W-1:0];
        it.dist_right  = dr[afbd_pkg::DIST_W-1:0];
        it.dist_bottom = db[afbd_pkg::DIST_W-1:0];
        send_request(it);
    endtask

    task automatic drain_boxes();
        while (pending_boxes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx,
                                input logic [afbd_pkg::DATA_W-1:0] value);
        logic [afbd_pkg::DATA_W-1:0] mask;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            afbd_pkg::REG_STRIDE: begin
                mask       = 32'hFF;
                cfg_stride = value[afbd_pkg::STRIDE_W-1:0];
            end
            afbd_pkg::REG_OFFSET: begin
                mask       = 32'hF;
                cfg_offset = value[afbd_pkg::OFFSET_W-1:0];
            end
            default: begin
                mask          = 32'hFFFF;
                cfg_threshold = value[afbd_pkg::SCORE_W-1:0];
            end
        endcase
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback, expected %0d actual %0d",
                     $time, idx, value & mask, prdata & mask);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic int rand_logit();
        case ($urandom_range(3))
            0:       return $signed(16'($urandom));
            1:       return int'($urandom_range(5120)) - 2048;
            2:       return int'($urandom_range(3)) * 64 - 64;
            default: return int'($urandom_range(1200)) - 1000;
        endcase
    endfunction

    task automatic send_random_cell(input int len);
        for (int i = 0; i < len; i++) begin
            send_logit(rand_logit(), i == len - 1, $urandom, $urandom,
                       $signed(16'($urandom)), $signed(16'($urandom)),
                       $signed(16'($urandom)), $signed(16'($urandom)));
        end
    endtask

    task automatic test_directed_basics();
        send_logit(0, 1, 0, 0, 0, 0, 0, 0);
        send_logit(32767, 1, 1023, 1023, 32767, 32767, -32768, -32768);
        send_logit(-32768, 1, 5, 6, 100, 100, 100, 100);
        send_logit(100, 0, 3, 4, 0, 0, 0, 0);
        send_logit(100, 0, 3, 4, 0, 0, 0, 0);
        send_logit(50, 1, 3, 4, 16, 32, 48, 64);
        send_logit(-1280, 0, 7, 8, 0, 0, 0, 0);
        send_logit(-768, 0, 7, 8, 0, 0, 0, 0);
        send_logit(-1792, 1, 7, 8, -16, -32, -48, -64);
        send_logit(383, 1, 1, 2, 3, 4, 5, 6);
        send_logit(384, 1, 1, 2, 3, 4, 5, 6);
        send_logit(3071, 1, 9, 9, 1, 1, 1, 1);
        send_logit(3072, 1, 9, 9, 1, 1, 1, 1);
        send_logit(-1000, 1, 11, 12, 1, 2, 3, 4);
        send_logit(-383, 1, 11, 12, 1, 2, 3, 4);
    endtask

    task automatic test_register_extremes();
        set_register(afbd_pkg::REG_STRIDE, 0);
        set_register(afbd_pkg::REG_OFFSET, 15);
        set_register(afbd_pkg::REG_THRESHOLD, 0);
        send_logit(-32768, 1, 1023, 1023, 32767, -32768, 32767, -32768);
        send_logit(-4000, 1, 512, 1, -5, 5, -5, 5);
        set_register(afbd_pkg::REG_STRIDE, 255);
        send_logit(1000, 1, 1023, 1023, -32768, 32767, 32767, -32768);
        send_logit(1000, 1, 0, 0, 32767, 32767, -32768, -32768);
        set_register(afbd_pkg::REG_THRESHOLD, 65535);
        send_logit(2000, 1, 100, 100, 0, 0, 0, 0);
        send_logit(3071, 1, 100, 100, 0, 0, 0, 0);
        send_logit(32767, 1, 1023, 0, 8, 8, 8, 8);
        set_register(afbd_pkg::REG_STRIDE, 1);
        set_register(afbd_pkg::REG_OFFSET, 0);
        set_register(afbd_pkg::REG_THRESHOLD, 1311);
        send_logit(-1000, 1, 1023, 1023, 0, 0, 0, 0);
        set_register(afbd_pkg::REG_STRIDE, 128);
        send_logit(256, 1, 1023, 1023, -100, 100, -100, 100);
    endtask

    task automatic test_class_saturation();
        for (int i = 0; i < 131; i++) begin
            send_logit((i == 129) ? 3000 : int'($urandom_range(4000)) - 2000, i == 130,
                       i, 130 - i, i, -i, i, -i);
        end
        for (int i = 0; i < 130; i++) begin
            send_logit((i >= 128) ? 2500 : 100, i == 129, 40, 41, 1, 2, 3, 4);
        end
    endtask

    task automatic test_random_cells(input int src_pct, input int snk_pct, input int n_items,
                                     input bit pause_once);
        int sent;
        int len;
        bit pause_pending;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        pause_pending = pause_once;
        set_register(afbd_pkg::REG_STRIDE, $urandom_range(255));
        set_register(afbd_pkg::REG_OFFSET, $urandom_range(15));
        set_register(afbd_pkg::REG_THRESHOLD,
                     ($urandom_range(1)) ? $urandom_range(8000) : $urandom);
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            send_random_cell(len);
            sent += len;
            if (pause_pending && sent >= n_items / 2) begin
                pause_pending = 1'b0;
                drain_boxes();
            end
        end
    endtask

    initial begin
        mismatch_count  = 0;
        boxes_predicted = 0;
        src_idle_pct    = 24;
        sink_idle_pct   = 70;
        cfg_stride      = afbd_pkg::STRIDE_RST;
        cfg_offset      = afbd_pkg::OFFSET_RST;
        cfg_threshold   = afbd_pkg::THRESHOLD_RST;
        best_logit_q    = 0;
        best_idx        = 0;
        seen_count      = 0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid       = 1'b0;
        in_ch.class_logit = '0;
        in_ch.last_class  = 1'b0;
        in_ch.grid_x      = '0;
        in_ch.grid_y      = '0;
        in_ch.dist_left   = '0;
        in_ch.dist_top    = '0;
        in_ch.dist_right  = '0;
        in_ch.dist_bottom = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_basics();
        test_register_extremes();
        test_class_saturation();
        test_random_cells(24, 70, 240, 1'b1);
        test_random_cells(70, 24, 240, 1'b0);
        test_random_cells(0, 0, 240, 1'b0);

        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
